// ===== rtl/core/urtb_pkg.sv =====
// Shared types and constants for the UART transmit/receive ring buffers.
`timescale 1ns / 1ps

package urtb_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned TX_DEPTH_DEF = 8;
    localparam int unsigned RX_DEPTH_DEF = 8;

    localparam logic [1:0] ACT_HOST_WRITE = 2'd0;
    localparam logic [1:0] ACT_TX_READY   = 2'd1;
    localparam logic [1:0] ACT_RX_BYTE    = 2'd2;
    localparam logic [1:0] ACT_HOST_READ  = 2'd3;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TX_FULL   = 3'd1,
        ST_RX_EMPTY  = 3'd2,
        ST_RX_OVERUN = 3'd3,
        ST_TX_NONE   = 3'd4
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctl;

    typedef struct packed {
        logic full;
        logic almost_full;
        logic empty;
        logic more;
    } t_ring_stat;

endpackage

// ===== rtl/core/uart_tx_rx_ring_buffers.sv =====
// Top level: action decode, transmit and receive rings, registered result.
// Result: registered; the result of an accepted transfer is valid on the next cycle.
// Throughput: one transfer per cycle while the result side is ready; the
//   single output register holds a stalled result and blocks further input.
// Reset: synchronous, active low; both rings empty, transmit interrupt off,
//   no result pending. No clearing pass; cell data is never read before written.
`timescale 1ns / 1ps

module uart_tx_rx_ring_buffers #(
    parameter int unsigned TX_DEPTH = urtb_pkg::TX_DEPTH_DEF,
    parameter int unsigned RX_DEPTH = urtb_pkg::RX_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_action,
    input  logic [urtb_pkg::BYTE_W-1:0]  i_byte_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_status,
    output logic                         o_tx_valid,
    output logic [urtb_pkg::BYTE_W-1:0]  o_tx_byte,
    output logic                         o_read_valid,
    output logic [urtb_pkg::BYTE_W-1:0]  o_read_byte,
    output logic                         o_tx_space_available,
    output logic                         o_rx_data_available,
    output logic                         o_tx_irq_enabled
);

    urtb_pkg::t_ring_ctl         w_tx_ctl;
    urtb_pkg::t_ring_ctl         w_rx_ctl;
    urtb_pkg::t_ring_stat        w_tx_stat;
    urtb_pkg::t_ring_stat        w_rx_stat;
    logic [urtb_pkg::BYTE_W-1:0] w_tx_head;
    logic [urtb_pkg::BYTE_W-1:0] w_rx_head;
    logic                        w_accept;

    logic                        r_irq_en;
    logic                        n_irq_en;
    logic                        r_out_valid;
    logic                        n_out_valid;
    urtb_pkg::t_status           r_status;
    urtb_pkg::t_status           n_status;
    logic                        r_tx_valid;
    logic                        n_tx_valid;
    logic [urtb_pkg::BYTE_W-1:0] r_tx_byte;
    logic [urtb_pkg::BYTE_W-1:0] n_tx_byte;
    logic                        r_rd_valid;
    logic                        n_rd_valid;
    logic [urtb_pkg::BYTE_W-1:0] r_rd_byte;
    logic [urtb_pkg::BYTE_W-1:0] n_rd_byte;
    logic                        r_tx_space;
    logic                        n_tx_space;
    logic                        r_rx_avail;
    logic                        n_rx_avail;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_tx_ctl   = '0;
        w_rx_ctl   = '0;
        n_irq_en   = r_irq_en;
        n_status   = urtb_pkg::ST_OK;
        n_tx_valid = 1'b0;
        n_tx_byte  = '0;
        n_rd_valid = 1'b0;
        n_rd_byte  = '0;
        unique case (i_action)
            urtb_pkg::ACT_HOST_WRITE: begin
                if (w_tx_stat.full) begin
                    n_status = urtb_pkg::ST_TX_FULL;
                end else begin
                    if (!r_irq_en) begin
                        n_tx_valid = 1'b1;
                        n_tx_byte  = i_byte_in;
                    end else begin
                        w_tx_ctl.push = w_accept;
                    end
                    n_irq_en = 1'b1;
                end
            end
            urtb_pkg::ACT_TX_READY: begin
                if (!w_tx_stat.empty) begin
                    n_tx_valid   = 1'b1;
                    n_tx_byte    = w_tx_head;
                    w_tx_ctl.pop = w_accept;
                end else begin
                    n_irq_en = 1'b0;
                    n_status = urtb_pkg::ST_TX_NONE;
                end
            end
            urtb_pkg::ACT_RX_BYTE: begin
                if (w_rx_stat.full) begin
                    n_status = urtb_pkg::ST_RX_OVERUN;
                end else begin
                    w_rx_ctl.push = w_accept;
                end
            end
            urtb_pkg::ACT_HOST_READ: begin
                if (w_rx_stat.empty) begin
                    n_status = urtb_pkg::ST_RX_EMPTY;
                end else begin
                    n_rd_valid   = 1'b1;
                    n_rd_byte    = w_rx_head;
                    w_rx_ctl.pop = w_accept;
                end
            end
            default: begin
                n_status = urtb_pkg::ST_OK;
            end
        endcase

        // occupancy flags as they stand after this transfer
        priority if (w_tx_ctl.push) begin
            n_tx_space = !w_tx_stat.almost_full;
        end else if (w_tx_ctl.pop) begin
            n_tx_space = 1'b1;
        end else begin
            n_tx_space = !w_tx_stat.full;
        end
        priority if (w_rx_ctl.push) begin
            n_rx_avail = 1'b1;
        end else if (w_rx_ctl.pop) begin
            n_rx_avail = w_rx_stat.more;
        end else begin
            n_rx_avail = !w_rx_stat.empty;
        end

        n_out_valid = w_accept || (r_out_valid && !i_out_ready);
    end

    urtb_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_tx_ctl),
        .i_push_data (i_byte_in),
        .o_stat      (w_tx_stat),
        .o_head_data (w_tx_head)
    );

    urtb_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_rx_ctl),
        .i_push_data (i_byte_in),
        .o_stat      (w_rx_stat),
        .o_head_data (w_rx_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_irq_en <= n_irq_en;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= n_status;
            r_tx_valid <= n_tx_valid;
            r_tx_byte  <= n_tx_byte;
            r_rd_valid <= n_rd_valid;
            r_rd_byte  <= n_rd_byte;
            r_tx_space <= n_tx_space;
            r_rx_avail <= n_rx_avail;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_status;
    assign o_tx_valid           = r_tx_valid;
    assign o_tx_byte            = r_tx_byte;
    assign o_read_valid         = r_rd_valid;
    assign o_read_byte          = r_rd_byte;
    assign o_tx_space_available = r_tx_space;
    assign o_rx_data_available  = r_rx_avail;
    assign o_tx_irq_enabled     = r_irq_en;

    a_one_byte_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_tx_valid && r_rd_valid))
        else $error("transmit and read byte in one result");

    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != urtb_pkg::ST_OK) |-> (!r_tx_valid && !r_rd_valid))
        else $error("byte delivered with error status");

    a_space_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_tx_space == !w_tx_stat.full && r_rx_avail == !w_rx_stat.empty))
        else $error("reported ring flags disagree with rings");

    a_stall_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_accept)
        else $error("transfer taken while result stalled");

endmodule

// ===== rtl/core/urtb_cell.sv =====
// One storage cell of a shifting ring: holds a byte, fills in order, shifts toward the head.
`timescale 1ns / 1ps

module urtb_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  urtb_pkg::t_ring_ctl          i_ctl,
    input  logic [urtb_pkg::BYTE_W-1:0]  i_push_data,
    input  logic                         i_prev_valid,
    input  logic                         i_next_valid,
    input  logic [urtb_pkg::BYTE_W-1:0]  i_next_data,
    output logic                         o_valid,
    output logic [urtb_pkg::BYTE_W-1:0]  o_data
);

    logic                        r_valid;
    logic                        n_valid;
    logic [urtb_pkg::BYTE_W-1:0] r_data;
    logic [urtb_pkg::BYTE_W-1:0] n_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        priority if (i_ctl.pop) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
        end else if (i_ctl.push && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_data  = i_push_data;
        end else begin
            n_valid = r_valid;
            n_data  = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/urtb_ring.sv =====
// Byte queue built as a row of shifting cells; head at cell 0.
`timescale 1ns / 1ps

module urtb_ring #(
    parameter int unsigned DEPTH = urtb_pkg::TX_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  urtb_pkg::t_ring_ctl          i_ctl,
    input  logic [urtb_pkg::BYTE_W-1:0]  i_push_data,
    output urtb_pkg::t_ring_stat         o_stat,
    output logic [urtb_pkg::BYTE_W-1:0]  o_head_data
);

    logic [DEPTH-1:0]                w_valid;
    logic [urtb_pkg::BYTE_W-1:0]     w_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                        w_prev_valid;
        logic                        w_next_valid;
        logic [urtb_pkg::BYTE_W-1:0] w_next_data;

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_data  = '0;
        end else begin : g_link
            assign w_next_valid = w_valid[g+1];
            assign w_next_data  = w_data[g+1];
        end

        urtb_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_push_data  (i_push_data),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_data  (w_next_data),
            .o_valid      (w_valid[g]),
            .o_data       (w_data[g])
        );
    end

    assign o_stat.full        = w_valid[DEPTH-1];
    assign o_stat.almost_full = w_valid[DEPTH-2];
    assign o_stat.empty       = !w_valid[0];
    assign o_stat.more        = w_valid[1];
    assign o_head_data        = w_data[0];

    // occupied cells are always a contiguous run starting at the head
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + 1'b1) & w_valid) == '0)
        else $error("ring occupancy not contiguous");

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.push && i_ctl.pop))
        else $error("ring push and pop in same cycle");

endmodule

// ===== test/uart_tx_rx_ring_buffers_tb.sv =====
// Testbench for the UART transmit/receive ring buffers: predicted results, random traffic.
`timescale 1ns / 1ps

module uart_tx_rx_ring_buffers_tb;
    import urtb_pkg::*;

    localparam int TX_DEPTH = TX_DEPTH_DEF;
    localparam int RX_DEPTH = RX_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX = 10;

    typedef struct {
        t_status    status;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       tx_space;
        logic       rx_avail;
        logic       tx_irq;
    } uart_result_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [1:0] i_action = ACT_HOST_WRITE;
    logic [7:0] i_byte_in = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [2:0] o_status;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_read_valid;
    logic [7:0] o_read_byte;
    logic       o_tx_space_available;
    logic       o_rx_data_available;
    logic       o_tx_irq_enabled;

    // predictor state
    logic [7:0] tx_ring [TX_DEPTH];
    logic [7:0] rx_ring [RX_DEPTH];
    int         tx_wr_idx = 0;
    int         tx_rd_idx = 0;
    int         tx_free = TX_DEPTH;
    logic       tx_irq_on = 1'b0;
    int         rx_wr_idx = 0;
    int         rx_rd_idx = 0;
    int         rx_count = 0;

    uart_result_t pending_results [$];
    int           mismatches = 0;
    bit           idle_en = 1'b1;
    int           ready_stall = 0;
    int           quiet_cycles = 0;

    uart_tx_rx_ring_buffers dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_action             (i_action),
        .i_byte_in            (i_byte_in),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_status             (o_status),
        .o_tx_valid           (o_tx_valid),
        .o_tx_byte            (o_tx_byte),
        .o_read_valid         (o_read_valid),
        .o_read_byte          (o_read_byte),
        .o_tx_space_available (o_tx_space_available),
        .o_rx_data_available  (o_rx_data_available),
        .o_tx_irq_enabled     (o_tx_irq_enabled)
    );

    always #1 i_clk = ~i_clk;

    function automatic uart_result_t uart_next_result(input logic [1:0] act,
                                                      input logic [7:0] b);
        uart_result_t r;
        r.status     = ST_OK;
        r.tx_valid   = 1'b0;
        r.tx_byte    = 8'h00;
        r.read_valid = 1'b0;
        r.read_byte  = 8'h00;
        case (act)
            ACT_HOST_WRITE: begin
                if (tx_free == 0) begin
                    r.status = ST_TX_FULL;
                end else begin
                    if (!tx_irq_on) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = b;
                    end else begin
                        tx_ring[tx_wr_idx] = b;
                        tx_wr_idx = (tx_wr_idx + 1) % TX_DEPTH;
                        tx_free--;
                    end
                    tx_irq_on = 1'b1;
                end
            end
            ACT_TX_READY: begin
                if (tx_free < TX_DEPTH) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = tx_ring[tx_rd_idx];
                    tx_rd_idx = (tx_rd_idx + 1) % TX_DEPTH;
                    tx_free++;
                end else begin
                    tx_irq_on = 1'b0;
                    r.status = ST_TX_NONE;
                end
            end
            ACT_RX_BYTE: begin
                if (rx_count >= RX_DEPTH) begin
                    r.status = ST_RX_OVERUN;
                end else begin
                    rx_ring[rx_wr_idx] = b;
                    rx_wr_idx = (rx_wr_idx + 1) % RX_DEPTH;
                    rx_count++;
                end
            end
            default: begin
                if (rx_count == 0) begin
                    r.status = ST_RX_EMPTY;
                end else begin
                    r.read_valid = 1'b1;
                    r.read_byte  = rx_ring[rx_rd_idx];
                    rx_rd_idx = (rx_rd_idx + 1) % RX_DEPTH;
                    rx_count--;
                end
            end
        endcase
        r.tx_space = (tx_free != 0);
        r.rx_avail = (rx_count != 0);
        r.tx_irq   = tx_irq_on;
        return r;
    endfunction

    // one transfer on the input side; starts and returns at a rising edge
    task automatic send_action(input logic [1:0] act, input logic [7:0] b);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_byte_in  <= b;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        pending_results.push_back(uart_next_result(act, b));
    endtask

    // output stall bursts
    always @(posedge i_clk) begin
        if (ready_stall > 0) begin
            ready_stall--;
            i_out_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            ready_stall = $urandom_range(0, 17);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        uart_result_t e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result transfer with nothing expected", $realtime);
            end else begin
                e = pending_results.pop_front();
                if (o_status !== e.status || o_tx_valid !== e.tx_valid ||
                    o_tx_byte !== e.tx_byte || o_read_valid !== e.read_valid ||
                    o_read_byte !== e.read_byte || o_tx_space_available !== e.tx_space ||
                    o_rx_data_available !== e.rx_avail ||
                    o_tx_irq_enabled !== e.tx_irq) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0t: exp st=%0d txv=%b txb=%h rdv=%b rdb=%h sp=%b av=%b irq=%b",
                                 $realtime, e.status, e.tx_valid, e.tx_byte, e.read_valid,
                                 e.read_byte, e.tx_space, e.rx_avail, e.tx_irq);
                        $display("%0t: got st=%0d txv=%b txb=%h rdv=%b rdb=%h sp=%b av=%b irq=%b",
                                 $realtime, o_status, o_tx_valid, o_tx_byte, o_read_valid,
                                 o_read_byte, o_tx_space_available, o_rx_data_available,
                                 o_tx_irq_enabled);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("uart_tx_rx_ring_buffers_tb: done, errors");
            $finish;
        end
    end

    task automatic test_directed();
        send_action(ACT_HOST_WRITE, 8'h00);   // irq off: straight to transmitter
        send_action(ACT_HOST_WRITE, 8'hFF);   // queued
        send_action(ACT_HOST_WRITE, 8'h5A);
        send_action(ACT_TX_READY, 8'hFF);
        send_action(ACT_TX_READY, 8'h00);
        send_action(ACT_TX_READY, 8'hA5);     // empty ring: irq off
        send_action(ACT_TX_READY, 8'h3C);     // empty again, irq already off
        send_action(ACT_HOST_WRITE, 8'h81);
        send_action(ACT_TX_READY, 8'h7E);
        send_action(ACT_HOST_READ, 8'hFF);    // read while empty
        send_action(ACT_RX_BYTE, 8'h00);
        send_action(ACT_RX_BYTE, 8'hFF);
        send_action(ACT_RX_BYTE, 8'h96);
        send_action(ACT_HOST_READ, 8'h00);
        send_action(ACT_HOST_READ, 8'h00);
        send_action(ACT_HOST_READ, 8'hC3);
        send_action(ACT_HOST_READ, 8'h18);
    endtask

    task automatic test_ring_limits();
        int k;
        for (k = 0; k < TX_DEPTH + 3; k++) send_action(ACT_HOST_WRITE, 8'($urandom));
        for (k = 0; k < TX_DEPTH + 2; k++) send_action(ACT_TX_READY, 8'($urandom));
        for (k = 0; k < RX_DEPTH + 3; k++) send_action(ACT_RX_BYTE, 8'($urandom));
        for (k = 0; k < RX_DEPTH + 2; k++) send_action(ACT_HOST_READ, 8'($urandom));
    endtask

    task automatic random_traffic(input int n, input int w_wr, input int w_rdy,
                                  input int w_rx, input int w_rd);
        int k;
        int pick;
        logic [1:0] act;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, w_wr + w_rdy + w_rx + w_rd - 1);
            if (pick < w_wr)
                act = ACT_HOST_WRITE;
            else if (pick < w_wr + w_rdy)
                act = ACT_TX_READY;
            else if (pick < w_wr + w_rdy + w_rx)
                act = ACT_RX_BYTE;
            else
                act = ACT_HOST_READ;
            send_action(act, 8'($urandom));
        end
    endtask

    task automatic test_fill_pressure();
        random_traffic(150, 5, 2, 5, 2);
    endtask

    task automatic test_drain_pressure();
        random_traffic(150, 2, 5, 2, 5);
    endtask

    task automatic test_balanced_mix();
        random_traffic(250, 1, 1, 1, 1);
    endtask

    task automatic test_phase_swings();
        int k;
        for (k = 0; k < 6; k++) begin
            random_traffic(20, 6, 1, 6, 1);
            random_traffic(20, 1, 6, 1, 6);
        end
    endtask

    task automatic test_back_to_back();
        idle_en = 1'b0;
        random_traffic(120, 3, 2, 3, 2);
        random_traffic(120, 2, 3, 2, 3);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_ring_limits();
        test_fill_pressure();
        test_drain_pressure();
        test_phase_swings();
        test_balanced_mix();
        test_back_to_back();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("uart_tx_rx_ring_buffers_tb: done, clean");
        else
            $display("uart_tx_rx_ring_buffers_tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/urtb_pkg.sv
rtl/core/urtb_cell.sv
rtl/core/urtb_ring.sv
rtl/core/uart_tx_rx_ring_buffers.sv
test/uart_tx_rx_ring_buffers_tb.sv
